FILE: src/lfps_pkg.sv
package lfps_pkg;

  localparam int unsigned SampleW = 8;
  localparam int unsigned SumW    = 10;
  localparam int unsigned GainW   = 16;
  localparam int unsigned ErrW    = 10;
  localparam int unsigned DiffW   = 11;
  localparam int unsigned IntegW  = 16;
  localparam int unsigned NumW    = 18;
  localparam int unsigned QuoW    = 8;
  localparam int unsigned MulW    = 17;
  localparam int unsigned ProdW   = 2 * MulW;
  localparam int unsigned AccW    = 36;
  localparam int unsigned PaddrW  = 4;
  localparam int unsigned DataW   = 32;

  localparam logic [SumW-1:0]  ThresholdRst = 10'd200;
  localparam logic [GainW-1:0] GainPRst     = 16'd461;
  localparam logic [GainW-1:0] GainIRst     = 16'd0;
  localparam logic [GainW-1:0] GainDRst     = 16'd1216;

  localparam logic [1:0] RegThreshold = 2'd0;
  localparam logic [1:0] RegGainP     = 2'd1;
  localparam logic [1:0] RegGainI     = 2'd2;
  localparam logic [1:0] RegGainD     = 2'd3;

  localparam logic [7:0] SetPoint     = 8'd250;
  localparam logic [7:0] FullDuty     = 8'd255;
  localparam logic [7:0] JunctionDutyA = 8'd252;
  localparam logic [7:0] JunctionDutyB = 8'd255;

  typedef struct packed {
    logic [SampleW-1:0] center_sample;
    logic [SampleW-1:0] left_sample;
    logic [SampleW-1:0] right_sample;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pwm_channel_a;
    logic [7:0] pwm_channel_b;
    logic       junction_stop;
  } out_item_t;

  typedef struct packed {
    logic [SumW-1:0]  junction_threshold;
    logic [GainW-1:0] gain_p;
    logic [GainW-1:0] gain_i;
    logic [GainW-1:0] gain_d;
  } cfg_t;

  typedef enum logic [3:0] {
    StIdle,
    StSetup,
    StDiv,
    StUpdate,
    StMulP,
    StMulI,
    StMulD,
    StAcc,
    StFinish
  } state_e;

  typedef enum logic [1:0] {
    MulSelP,
    MulSelI,
    MulSelD
  } mul_sel_e;

  typedef struct packed {
    logic     load_in;
    logic     setup;
    logic     div_step;
    logic     update;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     acc_add;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic junction;
    logic div_last;
  } status_t;

endpackage

FILE: src/lfps_ctrl.sv
module lfps_ctrl import lfps_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.mul_sel = MulSelP;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = StSetup;
        end
      end
      StSetup: begin
        cmd_o.setup = 1'b1;
        state_d     = status_i.junction ? StFinish : StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = StUpdate;
        end
      end
      StUpdate: begin
        cmd_o.update = 1'b1;
        state_d      = StMulP;
      end
      StMulP: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MulSelP;
        state_d       = StMulI;
      end
      StMulI: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MulSelI;
        cmd_o.acc_add = 1'b1;
        state_d       = StMulD;
      end
      StMulD: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MulSelD;
        cmd_o.acc_add = 1'b1;
        state_d       = StAcc;
      end
      StAcc: begin
        cmd_o.acc_add = 1'b1;
        state_d       = StFinish;
      end
      StFinish: begin
        // The result register is loaded once the previous result has gone.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: src/lfps_dp.sv
module lfps_dp import lfps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  in_item_t  in_data_i,
  input  cmd_t      cmd_i,
  output status_t   status_o,
  output out_item_t out_data_o
);

  localparam logic signed [AccW-1:0] CorrMax = 36'sd255;
  localparam logic signed [AccW-1:0] CorrMin = -36'sd255;
  localparam logic signed [IntegW:0] IntegMax = 17'sd32767;
  localparam logic signed [IntegW:0] IntegMin = -17'sd32768;

  logic [SampleW-1:0] center_q, left_q, right_q;
  logic [SumW-1:0]    sum_q;
  logic [QuoW-1:0]    numlo_q;
  logic [SumW-1:0]    rem_q;
  logic [QuoW-1:0]    quo_q;
  logic [2:0]         cnt_q;
  logic               zero_q, jct_q, side_right_q;
  logic signed [ErrW-1:0]   p_q, prev_q;
  logic signed [DiffW-1:0]  d_q;
  logic signed [IntegW-1:0] integ_q;
  logic signed [ProdW-1:0]  prod_q;
  logic signed [AccW-1:0]   acc_q;
  out_item_t                out_q;

  logic [SumW-1:0]    sum_w, wsum_w;
  logic [SampleW-1:0] side_w;
  logic               use_right_w;
  logic [NumW-1:0]    num_w;
  logic [SumW+1:0]    trial_w;
  logic signed [ErrW-1:0]   p_w;
  logic signed [IntegW:0]   integ_sum_w;
  logic signed [IntegW-1:0] integ_w;
  logic signed [MulW-1:0]   mul_a_w, mul_b_w;
  logic signed [AccW-1:0]   acc_adj_w, corr_w;
  logic [7:0]               mag_w, duty_w;
  out_item_t                out_w;

  always_comb begin
    sum_w       = SumW'(center_q) + SumW'(left_q) + SumW'(right_q);
    use_right_w = (right_q <= left_q);
    side_w      = use_right_w ? right_q : left_q;
    wsum_w      = {side_w, 1'b0} + SumW'(center_q);
    num_w       = NumW'(wsum_w) * NumW'(SetPoint);
  end

  assign status_o.junction = (sum_w >= cfg_i.junction_threshold);
  assign status_o.div_last = (cnt_q == 3'd7);

  // Restoring division: the quotient never exceeds the set point, so the
  // upper numerator bits start below the divisor and eight steps suffice.
  assign trial_w = {1'b0, rem_q, numlo_q[QuoW-1]} - {2'b00, sum_q};

  always_comb begin
    p_w = zero_q ? '0 : $signed({2'b00, quo_q} - {2'b00, SetPoint});
    integ_sum_w = {integ_q[IntegW-1], integ_q} + {{(IntegW+1-ErrW){p_w[ErrW-1]}}, p_w};
    if (integ_sum_w > IntegMax) begin
      integ_w = IntegMax[IntegW-1:0];
    end else if (integ_sum_w < IntegMin) begin
      integ_w = IntegMin[IntegW-1:0];
    end else begin
      integ_w = integ_sum_w[IntegW-1:0];
    end
  end

  always_comb begin
    unique case (cmd_i.mul_sel)
      MulSelP: begin
        mul_a_w = {{(MulW-ErrW){p_q[ErrW-1]}}, p_q};
        mul_b_w = {1'b0, cfg_i.gain_p};
      end
      MulSelI: begin
        mul_a_w = {integ_q[IntegW-1], integ_q};
        mul_b_w = {1'b0, cfg_i.gain_i};
      end
      MulSelD: begin
        mul_a_w = {{(MulW-DiffW){d_q[DiffW-1]}}, d_q};
        mul_b_w = {1'b0, cfg_i.gain_d};
      end
      default: begin
        mul_a_w = '0;
        mul_b_w = '0;
      end
    endcase
  end

  // Division by 256 rounds toward zero via a bias of 255 on negative sums.
  always_comb begin
    acc_adj_w = acc_q[AccW-1] ? acc_q + 36'sd255 : acc_q;
    corr_w    = acc_adj_w >>> 8;
    if (corr_w > CorrMax) begin
      corr_w = CorrMax;
    end else if (corr_w < CorrMin) begin
      corr_w = CorrMin;
    end
    mag_w  = corr_w[AccW-1] ? 8'(-corr_w) : corr_w[7:0];
    duty_w = FullDuty - mag_w;
    out_w.pwm_channel_a = FullDuty;
    out_w.pwm_channel_b = FullDuty;
    out_w.junction_stop = 1'b0;
    if (jct_q) begin
      out_w.pwm_channel_a = JunctionDutyA;
      out_w.pwm_channel_b = JunctionDutyB;
      out_w.junction_stop = 1'b1;
    end else if (side_right_q == corr_w[AccW-1]) begin
      out_w.pwm_channel_a = duty_w;
    end else begin
      out_w.pwm_channel_b = duty_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      integ_q <= '0;
    end else if (cmd_i.setup && status_o.junction) begin
      prev_q  <= '0;
      integ_q <= '0;
    end else if (cmd_i.update) begin
      prev_q  <= p_w;
      integ_q <= integ_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      center_q <= in_data_i.center_sample;
      left_q   <= in_data_i.left_sample;
      right_q  <= in_data_i.right_sample;
    end
    if (cmd_i.setup) begin
      sum_q        <= sum_w;
      rem_q        <= num_w[NumW-1:QuoW];
      numlo_q      <= num_w[QuoW-1:0];
      quo_q        <= '0;
      cnt_q        <= '0;
      zero_q       <= (sum_w == '0);
      jct_q        <= status_o.junction;
      side_right_q <= use_right_w;
    end
    if (cmd_i.div_step) begin
      cnt_q   <= cnt_q + 3'd1;
      numlo_q <= {numlo_q[QuoW-2:0], 1'b0};
      if (!trial_w[SumW+1]) begin
        rem_q <= trial_w[SumW-1:0];
        quo_q <= {quo_q[QuoW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[SumW-2:0], numlo_q[QuoW-1]};
        quo_q <= {quo_q[QuoW-2:0], 1'b0};
      end
    end
    if (cmd_i.update) begin
      p_q   <= p_w;
      d_q   <= {p_w[ErrW-1], p_w} - {prev_q[ErrW-1], prev_q};
      acc_q <= '0;
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_a_w * mul_b_w;
    end
    if (cmd_i.acc_add) begin
      acc_q <= acc_q + {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};
    end
    if (cmd_i.finish) begin
      out_q <= out_w;
    end
  end

  assign out_data_o = out_q;

endmodule

FILE: src/line_follow_pd_steering_core.sv
// Line-follow steering controller. Each input transfer carries three line-sensor
// samples and yields exactly one output transfer with two motor duties and a
// junction flag. A sensor sum at or above the junction threshold stops the
// motors (duties 252/255) and clears the controller state; otherwise the line
// position is divided by the sensor sum in an 8-step serial divider and a PID
// correction is built with one shared 17x17 multiplier for the P, I and D terms.
// After acceptance an item passes through setup, the divider steps, the error
// update, the P, I and D products and the accumulation; only then is its result
// loaded and the next item can be taken (a junction item goes from setup to loading).
// A new item is accepted while the previous result still waits in the output
// register, but its own result is held back until that transfer has taken place.
// Registers sit on the APB port at byte offsets 0x0 (junction threshold),
// 0x4 (P gain), 0x8 (I gain) and 0xC (D gain), gains in unsigned Q8.8.
module line_follow_pd_steering_core import lfps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready
);

  cfg_t    cfg_q;
  cmd_t    cmd;
  status_t status;
  logic    wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.junction_threshold <= ThresholdRst;
      cfg_q.gain_p             <= GainPRst;
      cfg_q.gain_i             <= GainIRst;
      cfg_q.gain_d             <= GainDRst;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        RegThreshold: cfg_q.junction_threshold <= pwdata[SumW-1:0];
        RegGainP:     cfg_q.gain_p             <= pwdata[GainW-1:0];
        RegGainI:     cfg_q.gain_i             <= pwdata[GainW-1:0];
        RegGainD:     cfg_q.gain_d             <= pwdata[GainW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegThreshold: prdata = DataW'(cfg_q.junction_threshold);
      RegGainP:     prdata = DataW'(cfg_q.gain_p);
      RegGainI:     prdata = DataW'(cfg_q.gain_i);
      RegGainD:     prdata = DataW'(cfg_q.gain_d);
      default:      prdata = '0;
    endcase
  end

  lfps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lfps_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule
